// ----- hw/rtl/tdpq_pkg.sv -----
// tdpq_pkg: shared types and constants for the timed delivery priority queue
// used by tdpq_cell and timed_delivery_priority_queue; no dependencies
`default_nettype none

package tdpq_pkg;

  localparam int unsigned DEPTH_DEFAULT = 16;
  localparam int unsigned DELAY_W       = 16;
  localparam int unsigned ID_W          = 8;
  localparam int unsigned FILL_W        = 5;
  localparam int unsigned MODE_W        = 2;
  localparam int unsigned IN_DATA_W     = 40;
  localparam int unsigned OUT_DATA_W    = 16;

  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT  = 2'd0,
    MODE_ADVANCE = 2'd1,
    MODE_REWIND  = 2'd2,
    MODE_NOP     = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_INSERT,
    OP_SUB,
    OP_ADD,
    OP_SHIFT
  } cell_op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_COUNT,
    ST_DRAIN,
    ST_STATUS
  } state_e;

  typedef struct packed {
    cell_op_e           op;
    logic [DELAY_W-1:0] key_delay;
    logic [ID_W-1:0]    key_id;
    logic [DELAY_W-1:0] step;
  } cell_cmd_t;

  typedef struct packed {
    logic               valid;
    logic               gt;
    logic               zero;
    logic [DELAY_W-1:0] delay;
    logic [ID_W-1:0]    id;
  } cell_data_t;

endpackage

`default_nettype wire

// ----- hw/rtl/tdpq_cell.sv -----
// tdpq_cell: one slot of the sorted delay chain (occupancy, delay, identifier)
// depends on tdpq_pkg
`default_nettype none

module tdpq_cell (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire tdpq_pkg::cell_cmd_t  cmd_i,
  input  wire tdpq_pkg::cell_data_t left_i,
  input  wire tdpq_pkg::cell_data_t right_i,
  output tdpq_pkg::cell_data_t      data_o
);

  logic                          valid_q, valid_d;
  logic [tdpq_pkg::DELAY_W-1:0]  delay_q, delay_d;
  logic [tdpq_pkg::ID_W-1:0]     id_q, id_d;
  logic                          gt;
  logic [tdpq_pkg::DELAY_W:0]    sum;

  assign gt  = valid_q && (delay_q > cmd_i.key_delay);
  assign sum = {1'b0, delay_q} + {1'b0, cmd_i.step};

  assign data_o.valid = valid_q;
  assign data_o.gt    = gt;
  assign data_o.zero  = valid_q && (delay_q == '0);
  assign data_o.delay = delay_q;
  assign data_o.id    = id_q;

  always_comb begin
    valid_d = valid_q;
    delay_d = delay_q;
    id_d    = id_q;
    case (cmd_i.op)
      tdpq_pkg::OP_INSERT: begin
        if (left_i.gt) begin
          valid_d = 1'b1;
          delay_d = left_i.delay;
          id_d    = left_i.id;
        end else if ((gt || !valid_q) && left_i.valid) begin
          valid_d = 1'b1;
          delay_d = cmd_i.key_delay;
          id_d    = cmd_i.key_id;
        end
      end
      tdpq_pkg::OP_SUB: begin
        delay_d = (delay_q > cmd_i.step) ? delay_q - cmd_i.step : '0;
      end
      tdpq_pkg::OP_ADD: begin
        delay_d = sum[tdpq_pkg::DELAY_W] ? '1 : sum[tdpq_pkg::DELAY_W-1:0];
      end
      tdpq_pkg::OP_SHIFT: begin
        valid_d = right_i.valid;
        delay_d = right_i.delay;
        id_d    = right_i.id;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    delay_q <= delay_d;
    id_q    <= id_d;
  end

endmodule

`default_nettype wire

// ----- hw/rtl/timed_delivery_priority_queue.sv -----
// timed_delivery_priority_queue: top level with sequencer, output register and cell chain
// depends on tdpq_pkg and tdpq_cell
`default_nettype none

// Pending items sit in a row of DEPTH cells, sorted by remaining delay with
// ties in arrival order. One input transaction is handled at a time: an
// insert, rewind or unused mode passes from acceptance through one
// chain-wide update to the status result; an advance runs its chain-wide
// update, then works out the new fill count in a state of its own before
// the first delivery, then delivers due items through the head cell one per
// cycle while the output accepts them, until the head is no longer due, and
// then gives its status. Stalls on the output side hold the drain and status.
// After reset the queue is empty and ready at once, with no clearing pass.
// fill_count carries the pending count in its low five bits.
module timed_delivery_priority_queue #(
  parameter int unsigned DEPTH = tdpq_pkg::DEPTH_DEFAULT
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  // item_id [7:0], delay_minutes [23:8], time_step [39:24]
  input  wire logic [tdpq_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // mode [1:0]
  input  wire logic [tdpq_pkg::MODE_W-1:0]        s_axis_tuser,
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  // delivered_id [7:0], status [8], fill_count [13:9], zero [15:14]
  output logic [tdpq_pkg::OUT_DATA_W-1:0]         m_axis_tdata,
  // delivered_valid [0]
  output logic                                    m_axis_tuser,
  output logic                                    m_axis_tlast
);

  localparam int unsigned CW = $clog2(DEPTH + 1);

  tdpq_pkg::state_e              state_q, state_d;
  tdpq_pkg::mode_e               mode_q;
  logic [tdpq_pkg::ID_W-1:0]     id_q;
  logic [tdpq_pkg::DELAY_W-1:0]  key_q;
  logic [tdpq_pkg::DELAY_W-1:0]  step_q;
  logic [CW-1:0]                 count_q, count_d;
  logic                          status_q, status_d;
  logic                          full;
  logic [CW-1:0]                 zeros;

  logic                          out_valid_q, out_valid_d;
  logic [tdpq_pkg::ID_W-1:0]     out_id_q, out_id_d;
  logic                          out_status_q, out_status_d;
  logic [tdpq_pkg::FILL_W-1:0]   out_fill_q, out_fill_d;
  logic                          out_dv_q, out_dv_d;
  logic                          out_last_q, out_last_d;
  logic                          out_free;
  logic                          accept;

  tdpq_pkg::cell_cmd_t           cmd;
  tdpq_pkg::cell_data_t          cell_data [DEPTH];
  tdpq_pkg::cell_data_t          head_left;
  tdpq_pkg::cell_data_t          tail_right;
  logic [DEPTH-1:0]              valid_vec;

  assign full     = (count_q == CW'(DEPTH));
  assign out_free = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == tdpq_pkg::ST_IDLE);
  assign accept   = s_axis_tvalid && s_axis_tready;

  // chain boundaries: cell 0 sees an occupied neighbour that never moves
  assign head_left  = '{valid: 1'b1, gt: 1'b0, zero: 1'b0, delay: '0, id: '0};
  assign tail_right = '{valid: 1'b0, gt: 1'b0, zero: 1'b0, delay: '0, id: '0};

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    tdpq_pkg::cell_data_t left, right;
    if (g == 0) begin : g_first
      assign left = head_left;
    end else begin : g_mid_l
      assign left = cell_data[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right = tail_right;
    end else begin : g_mid_r
      assign right = cell_data[g+1];
    end
    tdpq_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .cmd_i   (cmd),
      .left_i  (left),
      .right_i (right),
      .data_o  (cell_data[g])
    );
    assign valid_vec[g] = cell_data[g].valid;
  end

  // zero delays form a prefix; its end marks how many items leave
  always_comb begin
    zeros = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (cell_data[i].zero && ((i == DEPTH - 1) || !cell_data[(i + 1) % DEPTH].zero)) begin
        zeros = zeros | CW'(i + 1);
      end
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tdpq_pkg::ST_IDLE:   if (accept) state_d = tdpq_pkg::ST_EXEC;
      tdpq_pkg::ST_EXEC: begin
        state_d = (mode_q == tdpq_pkg::MODE_ADVANCE) ? tdpq_pkg::ST_COUNT
                                                     : tdpq_pkg::ST_STATUS;
      end
      tdpq_pkg::ST_COUNT:  state_d = tdpq_pkg::ST_DRAIN;
      tdpq_pkg::ST_DRAIN:  if (!cell_data[0].zero) state_d = tdpq_pkg::ST_STATUS;
      tdpq_pkg::ST_STATUS: if (out_free) state_d = tdpq_pkg::ST_IDLE;
      default:             state_d = tdpq_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    cmd.op        = tdpq_pkg::OP_HOLD;
    cmd.key_delay = key_q;
    cmd.key_id    = id_q;
    cmd.step      = step_q;
    count_d       = count_q;
    status_d      = status_q;
    out_valid_d   = out_valid_q && !m_axis_tready;
    out_id_d      = out_id_q;
    out_status_d  = out_status_q;
    out_fill_d    = out_fill_q;
    out_dv_d      = out_dv_q;
    out_last_d    = out_last_q;
    unique case (state_q)
      tdpq_pkg::ST_IDLE: begin
        status_d = 1'b0;
      end
      tdpq_pkg::ST_EXEC: begin
        case (mode_q)
          tdpq_pkg::MODE_INSERT: begin
            if (full) begin
              status_d = 1'b1;
            end else begin
              cmd.op  = tdpq_pkg::OP_INSERT;
              count_d = count_q + CW'(1);
            end
          end
          tdpq_pkg::MODE_ADVANCE: cmd.op = tdpq_pkg::OP_SUB;
          tdpq_pkg::MODE_REWIND:  cmd.op = tdpq_pkg::OP_ADD;
          default: ;
        endcase
      end
      tdpq_pkg::ST_COUNT: begin
        count_d = count_q - zeros;
      end
      tdpq_pkg::ST_DRAIN: begin
        if (cell_data[0].zero && out_free) begin
          cmd.op       = tdpq_pkg::OP_SHIFT;
          out_valid_d  = 1'b1;
          out_id_d     = cell_data[0].id;
          out_status_d = 1'b0;
          out_fill_d   = tdpq_pkg::FILL_W'(count_q);
          out_dv_d     = 1'b1;
          out_last_d   = 1'b0;
        end
      end
      tdpq_pkg::ST_STATUS: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_id_d     = '0;
          out_status_d = status_q;
          out_fill_d   = tdpq_pkg::FILL_W'(count_q);
          out_dv_d     = 1'b0;
          out_last_d   = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tdpq_pkg::ST_IDLE;
      count_q     <= '0;
      status_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      status_q    <= status_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q <= tdpq_pkg::mode_e'(s_axis_tuser);
      id_q   <= s_axis_tdata[7:0];
      key_q  <= s_axis_tdata[23:8];
      step_q <= s_axis_tdata[39:24];
    end
    out_id_q     <= out_id_d;
    out_status_q <= out_status_d;
    out_fill_q   <= out_fill_d;
    out_dv_q     <= out_dv_d;
    out_last_q   <= out_last_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_fill_q, out_status_q, out_id_q};
  assign m_axis_tuser  = out_dv_q;
  assign m_axis_tlast  = out_last_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("pending count beyond depth");

  a_valid_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((valid_vec + DEPTH'(1)) & valid_vec) == '0)
    else $error("occupied cells not contiguous from the head");

  a_count_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tdpq_pkg::ST_IDLE) |-> ($countones(valid_vec) == int'(count_q)))
    else $error("pending count disagrees with occupied cells");

endmodule

`default_nettype wire
